[sv/crlf_int_pkg.sv]
// ============================================================================
// crlf_int_pkg: shared types and constants for the CRLF decimal parser
// Parse phases, result status codes and the ASCII and range constants used
// by the digit accumulate step.
// ============================================================================
package crlf_int_pkg;

    // Parse phase
    typedef enum logic [1:0] {
        PH_FIRST       = 2'd0,   // awaiting first byte
        PH_AFTER_MINUS = 2'd1,   // digit expected after '-'
        PH_MORE        = 2'd2,   // CR or another digit expected
        PH_SKIP        = 2'd3    // byte after CR, result goes out on it
    } phase_t;

    // Result status
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_LONG = 2'd2
    } status_t;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned DIGIT_W  = 9;

    localparam logic [COUNT_W-1:0] MAX_DIGITS = 5'd21;
    localparam logic [COUNT_W-1:0] COUNT_SAT  = 5'd31;

    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic signed [DIGIT_W-1:0] CHAR_ZERO = 9'sd48;

    // acc * 10 stays in range only between these bounds (truncated division)
    localparam logic signed [VALUE_W-1:0] ACC_HI = 64'sd922337203685477580;
    localparam logic signed [VALUE_W-1:0] ACC_LO = -64'sd922337203685477580;

endpackage

[sv/crlf_decimal_int64_parser.sv]
// ============================================================================
// crlf_decimal_int64_parser: signed decimal parser, one byte/cycle unless held
// Accumulates digit bytes into a signed 64-bit value, ends on CR plus one
// skipped byte, reports overflow and too-long numbers.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready/s_in_byte) takes one stream byte per
//   request. An optional leading '-' negates the number; every byte in a
//   digit position adds (code - 48) to value*10. After CR the next byte is
//   skipped and the result request (m_value, m_status) is issued on it.
//   Overflow (status 1) or a 22nd digit-position byte (status 2) ends the
//   number at once with value 0. After every result the parser restarts.
//   m_valid rises in the cycle after the accepted byte that ends a number.
//   Throughput: one byte per cycle while results are taken as they come;
//   a result waiting on m_ready holds the input, whatever the next byte is.
//   The accumulate step (x10 by shift-add, add, range checks) is the
//   combinational logic that sets the rate.
//   Stall: with a result held and m_ready low, s_ready drops so no second
//   result can be lost; it rises again in the cycle m_ready is seen.
//   Reset (aresetn low, synchronous): parser returns to its start phase,
//   accumulator and digit count clear, no result pending.
// ============================================================================
module crlf_decimal_int64_parser (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [crlf_int_pkg::BYTE_W-1:0]      s_in_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [crlf_int_pkg::VALUE_W-1:0] m_value,
    output logic [1:0]                           m_status
);
    import crlf_int_pkg::*;

    phase_t                      phase_reg, phase_next;
    logic signed [VALUE_W-1:0]   acc_reg, acc_next;
    logic                        neg_reg, neg_next;
    logic [COUNT_W-1:0]          count_reg, count_next;

    logic                        out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]   out_value_reg, out_value_next;
    status_t                     out_status_reg, out_status_next;

    logic                        accept;
    logic                        emit;
    status_t                     emit_status;
    logic signed [VALUE_W-1:0]   emit_value;

    // Digit step datapath
    logic signed [DIGIT_W-1:0]   digit;
    logic signed [VALUE_W-1:0]   acc_x10;
    logic [VALUE_W:0]            sum;
    logic                        mul_ovf;
    logic                        add_ovf;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign digit   = $signed({1'b0, s_in_byte}) - CHAR_ZERO;
    assign acc_x10 = (acc_reg <<< 3) + (acc_reg <<< 1);
    assign mul_ovf = (acc_reg > ACC_HI) || (acc_reg < ACC_LO);
    assign sum     = {acc_x10[VALUE_W-1], acc_x10}
                   + {{(VALUE_W+1-DIGIT_W){digit[DIGIT_W-1]}}, digit};
    assign add_ovf = sum[VALUE_W] ^ sum[VALUE_W-1];

    // Parse state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            count_reg <= count_next;
        end
    end

    // Next parse state and result
    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_value  = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_FIRST, PH_AFTER_MINUS, PH_MORE: begin
                    priority if (phase_reg == PH_FIRST && s_in_byte == CHAR_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_AFTER_MINUS;
                    end else if (phase_reg == PH_MORE && count_reg >= MAX_DIGITS) begin
                        emit        = 1'b1;
                        emit_status = ST_LONG;
                    end else if (phase_reg == PH_MORE && s_in_byte == CHAR_CR) begin
                        phase_next = PH_SKIP;
                    end else if (mul_ovf || add_ovf) begin
                        emit        = 1'b1;
                        emit_status = ST_OVF;
                    end else begin
                        acc_next   = sum[VALUE_W-1:0];
                        count_next = (count_reg < COUNT_SAT) ? count_reg + 1'b1 : count_reg;
                        phase_next = PH_MORE;
                    end
                end
                PH_SKIP: begin
                    emit       = 1'b1;
                    emit_value = neg_reg ? -acc_reg : acc_reg;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase

            // Any result restarts the parser
            if (emit) begin
                phase_next = PH_FIRST;
                acc_next   = '0;
                neg_next   = 1'b0;
                count_next = '0;
            end
        end
    end

    // Result register
    always_comb begin
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (emit) begin
            out_valid_next  = 1'b1;
            out_value_next  = emit_value;
            out_status_next = emit_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;

`ifndef SYNTHESIS
    // Error results always carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_value == '0))
        else $error("error result with nonzero value");

    // A byte taken in the skip phase always produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_SKIP) |=> m_valid)
        else $error("skip byte did not produce a result");

    // Start phase implies a cleared accumulator and digit count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FIRST) |-> (acc_reg == '0 && count_reg == '0 && !neg_reg))
        else $error("start phase with stale parse state");

    // Digit count never passes the length limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_DIGITS)
        else $error("digit count beyond limit");
`endif

endmodule

[tb/crlf_int_checker.sv]
// ============================================================================
// crlf_int_checker: prediction and compare for the CRLF decimal parser
// Watches both channels, runs its own byte-by-byte copy of the parse state,
// queues the result request that each accepted byte should produce, and
// compares every accepted result request against the oldest one queued.
// ============================================================================
`timescale 1ns / 1ps

module crlf_int_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic [crlf_int_pkg::BYTE_W-1:0]         s_in_byte,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic signed [crlf_int_pkg::VALUE_W-1:0] m_value,
    input  logic [1:0]                              m_status,
    output int                                      fail_count,
    output int                                      pending
);
    import crlf_int_pkg::*;

    // Wide bounds for the x10 and add range checks
    localparam logic signed [71:0] WIDE_MAX = 72'sd9223372036854775807;
    localparam logic signed [71:0] WIDE_MIN = -72'sd9223372036854775808;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } parse_result_t;

    parse_result_t       parsed_q[$];
    parse_result_t       got_res;
    parse_result_t       want_res;
    parse_result_t       new_res;
    int                  err_total = 0;

    // Predicted parse state
    phase_t              pr_phase;
    logic signed [63:0]  pr_acc;
    logic                pr_neg;
    logic [COUNT_W-1:0]  pr_count;

    task automatic report_mismatch(input string what);
        $display("[%0t ns] mismatch: %s", $time, what);
        err_total++;
    endtask

    function automatic void clear_parse();
        pr_phase = PH_FIRST;
        pr_acc   = '0;
        pr_neg   = 1'b0;
        pr_count = '0;
    endfunction

    // One digit-position byte: acc*10 + (code - 48), overflow ends the number
    function automatic bit accumulate_digit(input logic [7:0] b, output parse_result_t res);
        logic signed [8:0]  term;
        logic signed [71:0] prod;
        logic signed [71:0] sum;
        res  = '0;
        term = $signed({1'b0, b}) - 9'sd48;
        prod = $signed({{8{pr_acc[63]}}, pr_acc}) * 72'sd10;
        sum  = prod + term;
        if (prod > WIDE_MAX || prod < WIDE_MIN || sum > WIDE_MAX || sum < WIDE_MIN) begin
            res.status = ST_OVF;
            clear_parse();
            return 1'b1;
        end
        pr_acc = sum[63:0];
        if (pr_count != COUNT_SAT)
            pr_count = pr_count + 1'b1;
        pr_phase = PH_MORE;
        return 1'b0;
    endfunction

    // Advance the parse by one byte; returns 1 when a result request is due
    function automatic bit parse_byte(input logic [7:0] b, output parse_result_t res);
        res = '0;
        case (pr_phase)
            PH_FIRST: begin
                if (b == CHAR_MINUS) begin
                    pr_neg   = 1'b1;
                    pr_phase = PH_AFTER_MINUS;
                    return 1'b0;
                end
                return accumulate_digit(b, res);
            end
            PH_AFTER_MINUS: begin
                return accumulate_digit(b, res);
            end
            PH_MORE: begin
                // too many digit bytes: ends on this byte, CR or not
                if (pr_count >= MAX_DIGITS) begin
                    res.status = ST_LONG;
                    clear_parse();
                    return 1'b1;
                end
                if (b == CHAR_CR) begin
                    pr_phase = PH_SKIP;
                    return 1'b0;
                end
                return accumulate_digit(b, res);
            end
            default: begin
                // skipped byte after CR carries the value out, negation wraps
                res.value  = pr_neg ? -pr_acc : pr_acc;
                res.status = ST_OK;
                clear_parse();
                return 1'b1;
            end
        endcase
    endfunction

    // Compare outgoing requests first, then predict from the incoming byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            parsed_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got_res.value  = m_value;
                got_res.status = m_status;
                if (parsed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result request value %0d status %0d",
                                              $signed(got_res.value), got_res.status));
                end else begin
                    want_res = parsed_q.pop_front();
                    if (got_res.value !== want_res.value)
                        report_mismatch($sformatf("value %0d, predicted %0d",
                                                  $signed(got_res.value),
                                                  $signed(want_res.value)));
                    if (got_res.status !== want_res.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  got_res.status, want_res.status));
                end
            end
            if (s_valid && s_ready) begin
                if (parse_byte(s_in_byte, new_res))
                    parsed_q = {parsed_q, new_res};
            end
        end
        fail_count <= err_total;
        pending    <= parsed_q.size();
    end

endmodule

[tb/tb_crlf_decimal_int64_parser.sv]
// ============================================================================
// tb_crlf_decimal_int64_parser: stimulus and verdict for the decimal parser
// Feeds short hand-picked byte strings, then a random mix of numbers, range
// corners, long zero runs, non-digit bytes and loose noise, with random idle
// bursts on both channels and one long result-side hold-off.
// ============================================================================
`timescale 1ns / 1ps

module tb_crlf_decimal_int64_parser;
    import crlf_int_pkg::*;

    localparam int ITEM_TARGET  = 1200;
    localparam int CALM_AFTER   = 1050;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic [BYTE_W-1:0]          s_in_byte = '0;
    logic                       m_ready   = 1'b0;
    wire                        s_ready;
    wire                        m_valid;
    wire signed [VALUE_W-1:0]   m_value;
    wire [1:0]                  m_status;

    int         fail_count;
    int         pending;
    int         bytes_sent   = 0;
    int         quiet_cycles = 0;
    bit         idle_on      = 1'b1;
    bit         hold_req     = 1'b0;
    logic [7:0] text_q[$];

    string corner_nums[6] = '{"9223372036854775807", "-9223372036854775808",
                              "-9223372036854775807", "9223372036854775808",
                              "92233720368547758070", "922337203685477580"};

    always #10 aclk = ~aclk;

    crlf_decimal_int64_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_status  (m_status)
    );

    crlf_int_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_status   (m_status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one byte request, with an occasional idle burst in front
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() != 0)
            send_byte(text_q.pop_front());
    endtask

    // Append one byte to the text waiting to be sent
    function automatic void queue_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    // Mirrored digits carry '0' - digit, so the accumulator runs negative
    function automatic void queue_number(input string digits, input bit mirror);
        for (int i = 0; i < digits.len(); i++) begin
            if (mirror && digits[i] != CHAR_MINUS)
                queue_byte(8'h60 - digits[i]);
            else
                queue_byte(digits[i]);
        end
    endfunction

    function automatic void queue_end();
        queue_byte(CHAR_CR);
        queue_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic string random_digits(input int n, input bit zero_fill);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = $sformatf("%s%0d", s, (zero_fill && i < n - 1) ? 0 : $urandom_range(0, 9));
        return s;
    endfunction

    // Watchdog: cycles with no request accepted on either channel
    initial begin
        @(posedge aclk iff aresetn);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Result side: random ready bursts, one long hold-off on request
    initial begin
        repeat (10) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    end

    // Stimulus
    initial begin
        string num;
        bit    mirror;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero, minus, CR as first digit, '-' then CR, 0xFF and
        // 0x00 as digits, '-' taken as a digit after the sign
        queue_number("0", 1'b0);  queue_byte(CHAR_CR); queue_byte(8'h00);
        queue_number("-7", 1'b0); queue_byte(CHAR_CR); queue_byte(8'hFF);
        queue_byte(CHAR_CR); queue_end();
        queue_byte(CHAR_MINUS); queue_byte(CHAR_CR); queue_end();
        queue_byte(8'hFF); queue_end();
        queue_number("--", 1'b0); queue_end();
        queue_byte(8'h00); queue_end();
        send_text();

        // Random mix; the result side holds off at the start so input stalls
        hold_req = 1'b1;
        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent >= CALM_AFTER)
                idle_on = 1'b0;
            mirror = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: begin
                    num = random_digits($urandom_range(1, 19), 1'b0);
                    if ($urandom_range(0, 1))
                        num = {"-", num};
                    queue_number(num, mirror);
                    queue_end();
                end
                5, 6: begin
                    queue_number(corner_nums[$urandom_range(0, 5)], mirror);
                    if ($urandom_range(0, 1))
                        queue_number(random_digits(1, 1'b0), mirror);
                    queue_end();
                end
                7: begin
                    // long enough to overflow
                    queue_number(random_digits(20, 1'b0), mirror);
                    queue_end();
                end
                8, 9: begin
                    // leading zeros around the digit count limit
                    queue_number(random_digits($urandom_range(19, 23), 1'b1), mirror);
                    queue_end();
                end
                10, 11: begin
                    if ($urandom_range(0, 1))
                        queue_byte(CHAR_MINUS);
                    repeat ($urandom_range(1, 6))
                        queue_byte(8'($urandom_range(0, 255)));
                    queue_end();
                end
                12: begin
                    // loose noise, no terminator
                    repeat ($urandom_range(1, 4))
                        queue_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    num = random_digits($urandom_range(1, 4), 1'b0);
                    if ($urandom_range(0, 1))
                        num = {"-", num};
                    queue_number(num, mirror);
                    queue_end();
                end
            endcase
            send_text();
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/crlf_int_pkg.sv
sv/crlf_decimal_int64_parser.sv
tb/crlf_int_checker.sv
tb/tb_crlf_decimal_int64_parser.sv
